/* sv/dfr_pkg.sv */
// shared types and constants for the dielectric fresnel reflectance block
package dfr_pkg;

  localparam int IN_FRAC       = 14;
  localparam int FRAC_BITS_DEF = 14;
  localparam int IDX_W         = 15;
  localparam int COS_W         = 16;
  localparam int OUT_W         = 16;
  localparam int RATIO_FRAC    = 15;
  localparam int RATIO_QW      = 16;

  localparam logic signed [COS_W-1:0] COS_MAX = 16'sd16384;
  localparam logic signed [COS_W-1:0] COS_MIN = -16'sd16384;
  localparam logic [OUT_W-1:0]        OUT_ONE = 16'd32768;

  typedef struct packed {
    logic signed [COS_W-1:0] cos_incident;
    logic [IDX_W-1:0]        index_incident;
    logic [IDX_W-1:0]        index_transmit;
  } in_t;

  typedef struct packed {
    logic [OUT_W-1:0] reflectance;
    logic             total_internal;
  } out_t;

endpackage

/* sv/dielectric_fresnel_reflectance.sv */
// unpolarized dielectric fresnel reflectance, fully pipelined top level
// Takes one request per cycle (busy is high only during reset) and returns its result
// with a one-cycle out_valid strobe, after it has passed the input registers, the two
// bit-per-stage square roots, the sine divider and the 16-stage amplitude ratio dividers.
// Results cannot be held off, so the receiver must take every strobe.
module dielectric_fresnel_reflectance import dfr_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int FW  = FRAC_BITS + 1;
  localparam int SQ  = 2 * FW;
  localparam int NW1 = IDX_W + FW;
  localparam int PW  = IDX_W + FW;
  localparam int DW  = PW + 1;
  localparam int RNW = PW + RATIO_FRAC;
  localparam int SB1 = 2 * IDX_W + FW + 1;
  localparam int LAT = 8 + 2 * FW + FRAC_BITS + RATIO_QW;
  localparam logic [SQ-1:0] ONE2 = SQ'(1) << (2 * FRAC_BITS);

  // input stage
  logic signed [COS_W-1:0] cs_sat;
  logic                    leave;
  logic [IDX_W-1:0]        mag;
  logic [FW-1:0]           c_scaled;
  logic                    accept;

  logic             v0_r;
  logic [FW-1:0]    c0_r;
  logic [IDX_W-1:0] ei0_r;
  logic [IDX_W-1:0] et0_r;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  always_comb begin
    cs_sat = in_data.cos_incident;
    if (in_data.cos_incident > COS_MAX) begin
      cs_sat = COS_MAX;
    end else if (in_data.cos_incident < COS_MIN) begin
      cs_sat = COS_MIN;
    end
    leave = cs_sat <= 0;
    mag   = leave ? IDX_W'(-cs_sat) : IDX_W'(cs_sat);
  end

  if (FRAC_BITS >= IN_FRAC) begin : g_up
    assign c_scaled = FW'(mag) << (FRAC_BITS - IN_FRAC);
  end else begin : g_down
    assign c_scaled = FW'(mag >> (IN_FRAC - FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= accept;
    end
    c0_r  <= c_scaled;
    ei0_r <= leave ? in_data.index_transmit : in_data.index_incident;
    et0_r <= leave ? in_data.index_incident : in_data.index_transmit;
  end

  // one minus cosine squared
  logic            v1_r;
  logic [SQ-1:0]   s1_r;
  logic [SB1-1:0]  sb1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v0_r;
    end
    s1_r  <= ONE2 - SQ'(c0_r) * SQ'(c0_r);
    sb1_r <= {ei0_r, et0_r, c0_r, et0_r == '0};
  end

  logic           vsi;
  logic [FW-1:0]  sin_i;
  logic [SB1-1:0] sbsi;

  dfr_sqrt #(.R(FW), .SB(SB1)) u_sqrt_sin (
    .clk, .rst_n,
    .in_valid(v1_r), .in_v(s1_r), .in_sb(sb1_r),
    .out_valid(vsi), .out_root(sin_i), .out_sb(sbsi)
  );

  // snell numerator
  logic           v2_r;
  logic [NW1-1:0] num2_r;
  logic [SB1-1:0] sb2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= vsi;
    end
    num2_r <= NW1'(sbsi[SB1-1 -: IDX_W]) * NW1'(sin_i);
    sb2_r  <= sbsi;
  end

  // total internal reflection check
  logic             v3_r;
  logic [NW1-1:0]   num3_r;
  logic [SB1-1:0]   sb3_r;
  logic [IDX_W-1:0] et2;
  logic             tir2;

  assign et2  = sb2_r[SB1-IDX_W-1 -: IDX_W];
  assign tir2 = sb2_r[0] || (num2_r >= (NW1'(et2) << FRAC_BITS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    num3_r <= num2_r;
    sb3_r  <= {sb2_r[SB1-1:1], tir2};
  end

  logic                 vst;
  logic [FRAC_BITS-1:0] sin_t;
  logic [SB1-1:0]       sbst;

  dfr_div #(.NW(NW1), .DW(IDX_W), .Q(FRAC_BITS), .SB(SB1)) u_div_sin (
    .clk, .rst_n,
    .in_valid(v3_r), .in_num(num3_r), .in_den(sb3_r[SB1-IDX_W-1 -: IDX_W]), .in_sb(sb3_r),
    .out_valid(vst), .out_quo(sin_t), .out_sb(sbst)
  );

  // one minus refracted sine squared
  logic           v4_r;
  logic [SQ-1:0]  s4_r;
  logic [SB1-1:0] sb4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= vst;
    end
    s4_r  <= ONE2 - SQ'(sin_t) * SQ'(sin_t);
    sb4_r <= sbst;
  end

  logic           vct;
  logic [FW-1:0]  cos_t;
  logic [SB1-1:0] sbct;

  dfr_sqrt #(.R(FW), .SB(SB1)) u_sqrt_cos (
    .clk, .rst_n,
    .in_valid(v4_r), .in_v(s4_r), .in_sb(sb4_r),
    .out_valid(vct), .out_root(cos_t), .out_sb(sbct)
  );

  // amplitude ratio terms
  logic             v5_r;
  logic [PW-1:0]    pa_r, pb_r, sa_r, sb_r;
  logic             tir5_r;
  logic [IDX_W-1:0] ei_c, et_c;
  logic [FW-1:0]    c_c;

  assign ei_c = sbct[SB1-1 -: IDX_W];
  assign et_c = sbct[SB1-IDX_W-1 -: IDX_W];
  assign c_c  = sbct[FW:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= vct;
    end
    pa_r   <= PW'(et_c) * PW'(c_c);
    pb_r   <= PW'(ei_c) * PW'(cos_t);
    sa_r   <= PW'(ei_c) * PW'(c_c);
    sb_r   <= PW'(et_c) * PW'(cos_t);
    tir5_r <= sbct[0];
  end

  // differences and sums
  logic          v6_r;
  logic [RNW-1:0] npar_r, nperp_r;
  logic [DW-1:0]  dpar_r, dperp_r;
  logic           zpar_r, zperp_r, tir6_r;
  logic [PW-1:0]  dfpar, dfperp;
  logic [DW-1:0]  smpar, smperp;

  assign dfpar  = (pa_r >= pb_r) ? pa_r - pb_r : pb_r - pa_r;
  assign dfperp = (sa_r >= sb_r) ? sa_r - sb_r : sb_r - sa_r;
  assign smpar  = DW'(pa_r) + DW'(pb_r);
  assign smperp = DW'(sa_r) + DW'(sb_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else begin
      v6_r <= v5_r;
    end
    npar_r  <= {dfpar, {RATIO_FRAC{1'b0}}};
    nperp_r <= {dfperp, {RATIO_FRAC{1'b0}}};
    dpar_r  <= smpar;
    dperp_r <= smperp;
    zpar_r  <= smpar == '0;
    zperp_r <= smperp == '0;
    tir6_r  <= tir5_r;
  end

  logic                vrp, vrs;
  logic [RATIO_QW-1:0] qpar, qperp;
  logic [1:0]          sbpar;
  logic                sbperp;

  dfr_div #(.NW(RNW), .DW(DW), .Q(RATIO_QW), .SB(2)) u_div_par (
    .clk, .rst_n,
    .in_valid(v6_r), .in_num(npar_r), .in_den(dpar_r), .in_sb({tir6_r, zpar_r}),
    .out_valid(vrp), .out_quo(qpar), .out_sb(sbpar)
  );

  dfr_div #(.NW(RNW), .DW(DW), .Q(RATIO_QW), .SB(1)) u_div_perp (
    .clk, .rst_n,
    .in_valid(v6_r), .in_num(nperp_r), .in_den(dperp_r), .in_sb(zperp_r),
    .out_valid(vrs), .out_quo(qperp), .out_sb(sbperp)
  );

  // squared ratios averaged
  logic [RATIO_QW-1:0] rp, rs;
  logic [31:0]         rsum;
  logic [OUT_W-1:0]    rsh;
  logic                out_valid_r;
  out_t                out_data_r;

  assign rp   = sbpar[0] ? OUT_ONE : qpar;
  assign rs   = sbperp ? OUT_ONE : qperp;
  assign rsum = 32'(rp) * 32'(rp) + 32'(rs) * 32'(rs);
  assign rsh  = (rsum[31:16] > OUT_ONE) ? OUT_ONE : rsum[31:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vrp & vrs;
    end
    out_data_r.reflectance    <= sbpar[1] ? OUT_ONE : rsh;
    out_data_r.total_internal <= sbpar[1];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_out_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.reflectance <= OUT_ONE)
    else $error("reflectance above one");

  a_tir_one : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.total_internal |-> out_data.reflectance == OUT_ONE)
    else $error("total internal reflection without full reflectance");

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result without matching request");

  a_lanes : assert property (@(posedge clk) disable iff (!rst_n)
    vrp == vrs)
    else $error("ratio lanes out of step");

endmodule

/* sv/dfr_sqrt.sv */
// pipelined integer square root, one result bit per stage
module dfr_sqrt import dfr_pkg::*; #(
  parameter int R  = FRAC_BITS_DEF + 1,
  parameter int SB = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [2*R-1:0]  in_v,
  input  logic [SB-1:0]   in_sb,
  output logic            out_valid,
  output logic [R-1:0]    out_root,
  output logic [SB-1:0]   out_sb
);

  logic [2*R-1:0] rem_r   [0:R-1];
  logic [R-1:0]   root_r  [0:R-1];
  logic           valid_r [0:R-1];
  logic [SB-1:0]  sb_r    [0:R-1];

  for (genvar k = 0; k < R; k++) begin : g_stage
    localparam int I = R - 1 - k;
    logic [2*R-1:0] rem_in;
    logic [R-1:0]   root_in;
    logic           valid_in;
    logic [SB-1:0]  sb_in;
    logic [2*R:0]   trial;
    logic [2*R:0]   diff;
    logic           ge;
    logic [2*R-1:0] rem_nxt;
    logic [R-1:0]   root_nxt;

    if (k == 0) begin : g_first
      assign rem_in   = in_v;
      assign root_in  = '0;
      assign valid_in = in_valid;
      assign sb_in    = in_sb;
    end else begin : g_next
      assign rem_in   = rem_r[k-1];
      assign root_in  = root_r[k-1];
      assign valid_in = valid_r[k-1];
      assign sb_in    = sb_r[k-1];
    end

    assign trial    = ((2*R+1)'(root_in) << (I + 1)) | ((2*R+1)'(1) << (2 * I));
    assign ge       = {1'b0, rem_in} >= trial;
    assign diff     = {1'b0, rem_in} - trial;
    assign rem_nxt  = ge ? diff[2*R-1:0] : rem_in;
    assign root_nxt = root_in | (R'(ge) << I);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= valid_in;
      end
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      sb_r[k]   <= sb_in;
    end
  end

  assign out_valid = valid_r[R-1];
  assign out_root  = root_r[R-1];
  assign out_sb    = sb_r[R-1];

endmodule

/* sv/dfr_div.sv */
// pipelined restoring divider, one quotient bit per stage
module dfr_div import dfr_pkg::*; #(
  parameter int NW = 32,
  parameter int DW = IDX_W,
  parameter int Q  = FRAC_BITS_DEF,
  parameter int SB = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SB-1:0] in_sb,
  output logic          out_valid,
  output logic [Q-1:0]  out_quo,
  output logic [SB-1:0] out_sb
);

  localparam int CW = (NW > DW + Q) ? NW : DW + Q;

  logic [NW-1:0] rem_r   [0:Q-1];
  logic [DW-1:0] den_r   [0:Q-1];
  logic [Q-1:0]  quo_r   [0:Q-1];
  logic          valid_r [0:Q-1];
  logic [SB-1:0] sb_r    [0:Q-1];

  for (genvar k = 0; k < Q; k++) begin : g_stage
    localparam int I = Q - 1 - k;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [Q-1:0]  quo_in;
    logic          valid_in;
    logic [SB-1:0] sb_in;
    logic [CW-1:0] dsh;
    logic [CW-1:0] diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in   = in_num;
      assign den_in   = in_den;
      assign quo_in   = '0;
      assign valid_in = in_valid;
      assign sb_in    = in_sb;
    end else begin : g_next
      assign rem_in   = rem_r[k-1];
      assign den_in   = den_r[k-1];
      assign quo_in   = quo_r[k-1];
      assign valid_in = valid_r[k-1];
      assign sb_in    = sb_r[k-1];
    end

    assign dsh  = CW'(den_in) << I;
    assign ge   = CW'(rem_in) >= dsh;
    assign diff = CW'(rem_in) - dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else begin
        valid_r[k] <= valid_in;
      end
      rem_r[k] <= ge ? diff[NW-1:0] : rem_in;
      den_r[k] <= den_in;
      quo_r[k] <= quo_in | (Q'(ge) << I);
      sb_r[k]  <= sb_in;
    end
  end

  assign out_valid = valid_r[Q-1];
  assign out_quo   = quo_r[Q-1];
  assign out_sb    = sb_r[Q-1];

endmodule

/* sim/tb_top.sv */
// testbench for the dielectric fresnel reflectance block: directed table then random requests
`timescale 1ns / 1ps
module tb_top;
  import dfr_pkg::*;

  localparam int F = FRAC_BITS_DEF;
  localparam int LATENCY = 3 * F + 26;
  localparam int WATCHDOG = 4000;
  localparam int N_RANDOM = 1200;
  localparam int IN_W = $bits(in_t);

  typedef struct {
    in_t  req;
    logic known;
    out_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;

  out_t expected_q[$];
  int   n_errors = 0;
  int   n_checked = 0;
  int   n_tir = 0;
  int   idle_cycles = 0;
  bit   watchdog_fired = 1'b0;

  dielectric_fresnel_reflectance DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #6 clk = ~clk;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned ratio_q15(longint unsigned a, longint unsigned b);
    longint unsigned d, n;
    d = a + b;
    n = (a >= b) ? a - b : b - a;
    if (d == 0) return 64'd32768;
    return (n << 15) / d;
  endfunction

  function automatic out_t fresnel(in_t r);
    out_t o;
    int cs;
    longint unsigned ni, nt, tmp, c, one, si, st, ct, rp, rs, sum;
    cs = int'(r.cos_incident);
    ni = r.index_incident;
    nt = r.index_transmit;
    one = 64'd1 << F;
    if (cs > 16384) cs = 16384;
    if (cs < -16384) cs = -16384;
    if (cs <= 0) begin
      tmp = ni; ni = nt; nt = tmp;
      c = longint'(-cs);
    end else begin
      c = longint'(cs);
    end
    if (F > IN_FRAC) c = c << (F - IN_FRAC);
    else c = c >> (IN_FRAC - F);
    o.reflectance = OUT_ONE;
    o.total_internal = 1'b1;
    if (nt == 0) return o;
    si = isqrt(one * one - c * c);
    st = (ni * si) / nt;
    if (st >= one) return o;
    ct = isqrt(one * one - st * st);
    rp = ratio_q15(nt * c, ni * ct);
    rs = ratio_q15(ni * c, nt * ct);
    sum = (rp * rp + rs * rs) >> 16;
    if (sum > 32768) sum = 32768;
    o.reflectance = sum[15:0];
    o.total_internal = 1'b0;
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_data.reflectance, -1);
      end else begin
        out_t e;
        e = expected_q.pop_front();
        n_checked++;
        if (out_data.reflectance !== e.reflectance)
          report_mismatch("reflectance", out_data.reflectance, e.reflectance);
        if (out_data.total_internal !== e.total_internal)
          report_mismatch("total_internal", out_data.total_internal, e.total_internal);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog expired with %0d results pending", expected_q.size());
        $display("tb_top failed");
        $finish;
      end
    end
  end

  task automatic send_request(in_t r, out_t want);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    repeat (gap) begin
      start <= 1'b0;
      in_data <= in_t'(IN_W'({$urandom, $urandom}));
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(want);
    if (want.total_internal) n_tir++;
    @(negedge clk);
  endtask

  function automatic in_t random_request();
    in_t r;
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) r.cos_incident = COS_W'($urandom);
    else if (k == 1) r.cos_incident = $urandom_range(0, 3) == 0 ? 16'sd0 : 16'sd16384;
    else r.cos_incident = 16'($signed($urandom_range(0, 32768)) - 16384);
    k = $urandom_range(0, 9);
    if (k == 0) begin
      r.index_incident = IDX_W'($urandom);
      r.index_transmit = IDX_W'($urandom);
    end else begin
      r.index_incident = IDX_W'($urandom_range(4096, k < 4 ? 32767 : 20480));
      r.index_transmit = IDX_W'($urandom_range(4096, k < 4 ? 32767 : 20480));
    end
    return r;
  endfunction

  dir_row_t dir_table[] = '{
    '{'{16'sd16384, 15'd8192, 15'd8192}, 1'b1, '{16'd0, 1'b0}},
    '{'{16'sd0, 15'd8192, 15'd0}, 1'b1, '{OUT_ONE, 1'b0}},
    '{'{16'sd100, 15'd8192, 15'd0}, 1'b1, '{OUT_ONE, 1'b1}},
    '{'{-16'sd100, 15'd0, 15'd8192}, 1'b1, '{OUT_ONE, 1'b1}},
    '{'{16'sd0, 15'd0, 15'd0}, 1'b1, '{OUT_ONE, 1'b1}},
    '{'{16'sd32767, 15'd8192, 15'd12288}, 1'b0, '{16'd0, 1'b0}},
    '{'{-16'sd32768, 15'd8192, 15'd12288}, 1'b0, '{16'd0, 1'b0}},
    '{'{-16'sd16384, 15'd12288, 15'd8192}, 1'b0, '{16'd0, 1'b0}},
    '{'{16'sd1, 15'd32767, 15'd4096}, 1'b1, '{OUT_ONE, 1'b1}},
    '{'{16'sd16384, 15'd32767, 15'd4096}, 1'b0, '{16'd0, 1'b0}},
    '{'{16'sd16384, 15'd4096, 15'd32767}, 1'b0, '{16'd0, 1'b0}},
    '{'{16'sd1, 15'd4096, 15'd32767}, 1'b0, '{16'd0, 1'b0}},
    '{'{16'sd0, 15'd12288, 15'd8192}, 1'b0, '{16'd0, 1'b0}},
    '{'{16'sd2000, 15'd12288, 15'd8192}, 1'b0, '{16'd0, 1'b0}},
    '{'{16'sd8000, 15'd12288, 15'd8192}, 1'b0, '{16'd0, 1'b0}},
    '{'{-16'sd2000, 15'd8192, 15'd12288}, 1'b0, '{16'd0, 1'b0}},
    '{'{16'sd11585, 15'd8192, 15'd10895}, 1'b0, '{16'd0, 1'b0}},
    '{'{16'sd16383, 15'd32767, 15'd32767}, 1'b0, '{16'd0, 1'b0}},
    '{'{-16'sd1, 15'd4096, 15'd4096}, 1'b0, '{16'd0, 1'b0}},
    '{'{16'sh7fff, 15'h7fff, 15'h7fff}, 1'b0, '{16'd0, 1'b0}},
    '{'{16'sh5555, 15'h2aaa, 15'h5555}, 1'b0, '{16'd0, 1'b0}}
  };

  initial begin
    int waited;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (dir_table[i]) begin
      send_request(dir_table[i].req,
                   dir_table[i].known ? dir_table[i].res : fresnel(dir_table[i].req));
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      in_t r;
      r = random_request();
      send_request(r, fresnel(r));
    end
    start <= 1'b0;
    waited = 0;
    while (expected_q.size() != 0 && waited < 20 * LATENCY) begin
      @(posedge clk);
      waited++;
    end
    repeat (LATENCY + 8) @(posedge clk);
    if (expected_q.size() != 0) report_mismatch("results left over", expected_q.size(), 0);
    $display("%0d directed and %0d random requests, %0d results checked, %0d total internal",
             dir_table.size(), N_RANDOM, n_checked, n_tir);
    if (n_errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/dfr_pkg.sv
sv/dfr_sqrt.sv
sv/dfr_div.sv
sv/dielectric_fresnel_reflectance.sv
sim/tb_top.sv
